// ----- rtl/dai_pkg.sv -----
package dai_pkg;

   localparam int DAI_MAX_ENTRIES = 256;
   localparam int DAI_DATA_W      = 32;

   // operation codes
   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_ERASE  = 3'd1;
   localparam logic [2:0] OP_GET    = 3'd2;
   localparam logic [2:0] OP_SET    = 3'd3;
   localparam logic [2:0] OP_QUERY  = 3'd4;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_INDEX = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_CLAMP = 2'd3;

   typedef struct packed {
      logic [2:0]         op;
      logic [8:0]         index;
      logic [8:0]         count;
      logic signed [31:0] value;
      logic               last_value;
   } dai_req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [8:0]         size_now;
      logic [9:0]         capacity_now;
      logic [1:0]         status;
   } dai_rsp_type;

endpackage

// ----- rtl/dynamic_array_insert_erase.sv -----
// Query, set and rejected items are answered straight from the idle state; get reads the
// RAM in S_GET; insert and erase shift elements in S_MOVE, one element per cycle through
// the RAM port pair. Busy is high while a get, insert or erase works, and no new item is
// taken then. Results appear on rsp_strobe for one cycle; the receiver cannot stall.
// Synchronous reset empties the array (size 0, capacity 1); stored data is left as is.
module dynamic_array_insert_erase
   import dai_pkg::*;
#(
   parameter int MAX_ENTRIES = DAI_MAX_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  dai_req_type req_item,
   output logic        busy,
   output logic        rsp_strobe,
   output dai_rsp_type rsp_item
);

   localparam int ADDR_W  = $clog2(MAX_ENTRIES);
   localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W   = (CNT_W > 10) ? CNT_W : 10;
   localparam int CAP_W   = CNT_W + 1;
   localparam int CAPX_W  = CMP_W + 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MOVE = 2'd1;
   localparam logic [1:0] S_GET  = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CAP_W-1:0]      cap_ff, cap_in;
   logic [ADDR_W-1:0]     src_ff, src_in;
   logic [ADDR_W-1:0]     dst_ff, dst_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic                  vld_ff, vld_in;
   logic                  dir_ins_ff, dir_ins_in;
   logic [ADDR_W-1:0]     ins_addr_ff, ins_addr_in;
   logic [DAI_DATA_W-1:0] ins_val_ff, ins_val_in;
   logic [1:0]            status_ff, status_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   dai_rsp_type           rsp_ff, rsp_in;

   logic                  ram_we;
   logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
   logic [DAI_DATA_W-1:0] ram_wdata, ram_rdata;

   logic [CMP_W-1:0]      idx_w, cur_w, num_w, avail_w, cut_w;
   logic                  idx_bad, idx_oob, full, grow;
   logic [ADDR_W-1:0]     step;
   logic [CMP_W-1:0]      size_x;
   logic [CAPX_W-1:0]     cap_x;

   dai_ram #(
      .WIDTH (DAI_DATA_W),
      .DEPTH (MAX_ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign idx_w   = CMP_W'(req_item.index);
   assign cur_w   = CMP_W'(count_ff);
   assign num_w   = CMP_W'(req_item.count);
   assign avail_w = cur_w - idx_w;
   assign cut_w   = (num_w > avail_w) ? avail_w : num_w;
   assign idx_bad = idx_w > cur_w;
   assign idx_oob = idx_w >= cur_w;
   assign full    = cur_w >= CMP_W'(MAX_ENTRIES);
   assign grow    = (CAP_W'(count_ff) + CAP_W'(1)) >= cap_ff;
   // shared pointer step: down for insert, up for erase
   assign step    = dir_ins_ff ? {ADDR_W{1'b1}} : ADDR_W'(1);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cap_in        = cap_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      rem_in        = rem_ff;
      vld_in        = 1'b0;
      dir_ins_in    = dir_ins_ff;
      ins_addr_in   = ins_addr_ff;
      ins_val_in    = ins_val_ff;
      status_in     = status_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      ram_we        = 1'b0;
      ram_waddr     = dst_ff;
      ram_wdata     = ram_rdata;
      ram_raddr     = src_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ram_raddr         = ADDR_W'(req_item.index);
               rsp_in.read_value = '0;
               rsp_in.status     = ST_OK;
               case (req_item.op)
                  OP_INSERT: begin
                     if (idx_bad) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = ST_INDEX;
                     end else if (full) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = ST_FULL;
                     end else begin
                        if (grow) begin
                           cap_in = cap_ff << 1;
                        end
                        count_in    = count_ff + CNT_W'(1);
                        rem_in      = CNT_W'(avail_w);
                        src_in      = ADDR_W'(count_ff - CNT_W'(1));
                        dst_in      = ADDR_W'(count_ff);
                        dir_ins_in  = 1'b1;
                        ins_addr_in = ADDR_W'(req_item.index);
                        ins_val_in  = req_item.value;
                        status_in   = ST_OK;
                        state_in    = S_MOVE;
                     end
                  end
                  OP_ERASE: begin
                     if (idx_bad) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = ST_INDEX;
                     end else begin
                        count_in   = count_ff - CNT_W'(cut_w);
                        rem_in     = CNT_W'(avail_w - cut_w);
                        src_in     = ADDR_W'(idx_w + cut_w);
                        dst_in     = ADDR_W'(req_item.index);
                        dir_ins_in = 1'b0;
                        status_in  = (num_w > avail_w) ? ST_CLAMP : ST_OK;
                        state_in   = S_MOVE;
                     end
                  end
                  OP_GET: begin
                     if (idx_oob) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = ST_INDEX;
                     end else begin
                        state_in = S_GET;
                     end
                  end
                  OP_SET: begin
                     rsp_strobe_in = 1'b1;
                     if (idx_oob) begin
                        rsp_in.status = ST_INDEX;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = ADDR_W'(req_item.index);
                        ram_wdata = req_item.value;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         S_MOVE: begin
            // read one element ahead, write it back in the next cycle
            if (rem_ff != '0) begin
               vld_in = 1'b1;
               rem_in = rem_ff - CNT_W'(1);
               src_in = src_ff + step;
            end
            if (vld_ff) begin
               ram_we = 1'b1;
               dst_in = dst_ff + step;
            end
            if (rem_ff == '0 && !vld_ff) begin
               if (dir_ins_ff) begin
                  ram_we    = 1'b1;
                  ram_waddr = ins_addr_ff;
                  ram_wdata = ins_val_ff;
               end
               rsp_strobe_in     = 1'b1;
               rsp_in.read_value = '0;
               rsp_in.status     = status_ff;
               state_in          = S_IDLE;
            end
         end
         S_GET: begin
            rsp_strobe_in     = 1'b1;
            rsp_in.read_value = ram_rdata;
            rsp_in.status     = ST_OK;
            state_in          = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      size_x              = CMP_W'(count_in);
      cap_x               = CAPX_W'(cap_in);
      rsp_in.size_now     = size_x[8:0];
      rsp_in.capacity_now = cap_x[9:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         cap_ff        <= CAP_W'(1);
         vld_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         cap_ff        <= cap_in;
         vld_ff        <= vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      rem_ff      <= rem_in;
      dir_ins_ff  <= dir_ins_in;
      ins_addr_ff <= ins_addr_in;
      ins_val_ff  <= ins_val_in;
      status_ff   <= status_in;
      rsp_ff      <= rsp_in;
   end

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> state_ff == S_IDLE)
      else $error("result strobe while an item is still in progress");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_strobe || busy))
      else $error("transfer accepted but neither a result nor work followed");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(MAX_ENTRIES))
      else $error("element count above store depth");

   a_cap_above_count: assert property (@(posedge clock) disable iff (reset)
      cap_ff > CAP_W'(count_ff))
      else $error("capacity does not exceed element count");

   a_no_move_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !vld_ff)
      else $error("pending shift write outside a move");

endmodule

// ----- rtl/dai_ram.sv -----
module dai_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- dv/dynamic_array_insert_erase_tb.sv -----
`timescale 1ns / 100ps

module dynamic_array_insert_erase_tb;
   import dai_pkg::*;

   localparam int LIMIT_CYCLES = 2_000_000;
   localparam int DRAIN_CYCLES = 300;

   class vector_scoreboard;
      logic signed [31:0] shadow_elems [DAI_MAX_ENTRIES];
      int                 shadow_size;
      int                 shadow_cap;
      dai_rsp_type        replies_due [$];
      int                 fails;

      function new();
         shadow_size = 0;
         shadow_cap  = 1;
         fails       = 0;
      endfunction

      // Work out the reply to one accepted command and update the shadow array.
      function void apply_command(dai_req_type cmd);
         int          idx;
         int          cnt;
         int          i;
         dai_rsp_type want;
         idx  = int'(cmd.index);
         cnt  = int'(cmd.count);
         want = '0;
         want.status = ST_OK;
         case (cmd.op)
            OP_INSERT: begin
               if (idx > shadow_size) begin
                  want.status = ST_INDEX;
               end else if (shadow_size >= DAI_MAX_ENTRIES) begin
                  want.status = ST_FULL;
               end else begin
                  while (shadow_size + 1 >= shadow_cap) shadow_cap = shadow_cap * 2;
                  for (i = shadow_size; i > idx; i--) shadow_elems[i] = shadow_elems[i - 1];
                  shadow_elems[idx] = cmd.value;
                  shadow_size++;
               end
            end
            OP_ERASE: begin
               if (idx > shadow_size) begin
                  want.status = ST_INDEX;
               end else begin
                  if (cnt > shadow_size - idx) begin
                     cnt = shadow_size - idx;
                     want.status = ST_CLAMP;
                  end
                  for (i = idx + cnt; i < shadow_size; i++) shadow_elems[i - cnt] = shadow_elems[i];
                  shadow_size = shadow_size - cnt;
               end
            end
            OP_GET: begin
               if (idx >= shadow_size) want.status = ST_INDEX;
               else want.read_value = shadow_elems[idx];
            end
            OP_SET: begin
               if (idx >= shadow_size) want.status = ST_INDEX;
               else shadow_elems[idx] = cmd.value;
            end
            default: begin
            end
         endcase
         want.size_now     = shadow_size[8:0];
         want.capacity_now = shadow_cap[9:0];
         replies_due.push_back(want);
      endfunction

      task log_mismatch(string msg);
         $display("ERROR @%0t: %s", $realtime, msg);
         fails++;
      endtask

      task check_reply(dai_rsp_type got);
         dai_rsp_type want;
         if (replies_due.size() == 0) begin
            log_mismatch("reply strobed with no command outstanding");
         end else begin
            want = replies_due.pop_front();
            if (got.read_value !== want.read_value)
               log_mismatch($sformatf("read_value got %0d expected %0d",
                                      got.read_value, want.read_value));
            if (got.size_now !== want.size_now)
               log_mismatch($sformatf("size_now got %0d expected %0d",
                                      got.size_now, want.size_now));
            if (got.capacity_now !== want.capacity_now)
               log_mismatch($sformatf("capacity_now got %0d expected %0d",
                                      got.capacity_now, want.capacity_now));
            if (got.status !== want.status)
               log_mismatch($sformatf("status field got %0d expected %0d",
                                      got.status, want.status));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   dai_req_type req_item = '0;
   logic        busy;
   logic        rsp_strobe;
   dai_rsp_type rsp_item;

   vector_scoreboard board = new();
   int               items_sent = 0;
   int               cycles = 0;

   dynamic_array_insert_erase dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_item   (req_item),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) board.check_reply(rsp_item);
   end

   function automatic dai_req_type make_cmd(logic [2:0] op, int idx, int cnt,
                                            logic [31:0] val, bit last);
      dai_req_type cmd;
      cmd.op         = op;
      cmd.index      = idx[8:0];
      cmd.count      = cnt[8:0];
      cmd.value      = val;
      cmd.last_value = last;
      return cmd;
   endfunction

   // Hold start low now and then, leaving calm stretches with no gaps at all.
   task automatic pace(int pct);
      if (pct != 0 && (items_sent % 80) >= 16 && $urandom_range(99) < pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic send(dai_req_type cmd, int pct);
      pace(pct);
      req_item <= cmd;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      board.apply_command(cmd);
      items_sent++;
   endtask

   task automatic random_seq(int pct);
      int n;
      int kind;
      int idx;
      int len;
      int cnt;
      int k;
      n    = board.shadow_size;
      kind = $urandom_range(99);
      // steer towards erase once the array grows, keeping shifts short
      if (n > 48 && $urandom_range(1) == 1) kind = 40;
      if (kind < 35) begin
         len = $urandom_range(1, ($urandom_range(9) == 0) ? 24 : 5);
         idx = $urandom_range(0, n);
         for (k = 0; k < len; k++)
            send(make_cmd(OP_INSERT, idx + k, $urandom_range(0, 511), $urandom,
                          k == len - 1), pct);
      end else if (kind < 50) begin
         idx = $urandom_range(0, n);
         if ($urandom_range(7) == 0) cnt = $urandom_range(0, 511);
         else cnt = $urandom_range(0, n - idx);
         send(make_cmd(OP_ERASE, idx, cnt, $urandom, 1'($urandom_range(1))), pct);
      end else if (kind < 75) begin
         if (n == 0 || $urandom_range(7) == 0) idx = n;
         else idx = $urandom_range(0, n - 1);
         send(make_cmd((kind < 65) ? OP_GET : OP_SET, idx, $urandom_range(0, 511),
                       $urandom, 1'($urandom_range(1))), pct);
      end else if (kind < 80) begin
         send(make_cmd(3'($urandom_range(4, 7)), $urandom_range(0, 511),
                       $urandom_range(0, 511), $urandom, 1'($urandom_range(1))), pct);
      end else begin
         send(make_cmd(3'($urandom_range(0, 7)), $urandom_range(0, 511),
                       $urandom_range(0, 511), $urandom, 1'($urandom_range(1))), pct);
      end
   endtask

   // Fill the array to the brim, push against the full limit, then cut it back.
   task automatic fill_to_capacity(int pct);
      int k;
      while (board.shadow_size < DAI_MAX_ENTRIES)
         send(make_cmd(OP_INSERT, $urandom_range(0, board.shadow_size), 0, $urandom,
                       board.shadow_size == DAI_MAX_ENTRIES - 1), pct);
      for (k = 0; k < 3; k++)
         send(make_cmd(OP_INSERT, $urandom_range(0, DAI_MAX_ENTRIES), 0, $urandom, 1'b1), pct);
      send(make_cmd(OP_GET, DAI_MAX_ENTRIES - 1, 0, 0, 1'b0), pct);
      send(make_cmd(OP_GET, 0, 0, 0, 1'b0), pct);
      send(make_cmd(OP_ERASE, $urandom_range(8, 24), 511, 0, 1'b0), pct);
   endtask

   initial begin
      int phase;
      int pct;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty array corners
      send(make_cmd(OP_QUERY, 0, 0, 0, 1'b0), 0);
      send(make_cmd(OP_GET, 0, 0, 0, 1'b0), 0);
      send(make_cmd(OP_SET, 0, 0, 32'h1234_5678, 1'b0), 0);
      send(make_cmd(OP_ERASE, 1, 1, 0, 1'b0), 0);
      send(make_cmd(OP_ERASE, 0, 0, 0, 1'b0), 0);
      send(make_cmd(OP_INSERT, 1, 0, 32'd5, 1'b1), 0);
      // growth from one through eight, extremes of value
      send(make_cmd(OP_INSERT, 0, 0, 32'h7fff_ffff, 1'b1), 0);
      send(make_cmd(OP_INSERT, 0, 0, 32'h8000_0000, 1'b1), 0);
      send(make_cmd(OP_INSERT, 2, 0, 32'hffff_ffff, 1'b1), 0);
      send(make_cmd(OP_INSERT, 1, 511, 32'h0, 1'b0), 0);
      send(make_cmd(OP_GET, 0, 0, 0, 1'b0), 0);
      send(make_cmd(OP_GET, 1, 0, 0, 1'b0), 0);
      send(make_cmd(OP_GET, 2, 0, 0, 1'b0), 0);
      send(make_cmd(OP_GET, 3, 0, 0, 1'b0), 0);
      send(make_cmd(OP_SET, 3, 0, 32'd12345, 1'b0), 0);
      send(make_cmd(OP_GET, 4, 0, 0, 1'b0), 0);
      send(make_cmd(OP_ERASE, 1, 1, 0, 1'b0), 0);
      send(make_cmd(OP_ERASE, 2, 511, 0, 1'b0), 0);
      send(make_cmd(OP_GET, 0, 0, 0, 1'b0), 0);
      send(make_cmd(3'd5, 511, 511, 32'hffff_ffff, 1'b1), 0);
      send(make_cmd(3'd7, 511, 511, 32'hffff_ffff, 1'b1), 0);
      send(make_cmd(OP_INSERT, 511, 0, 32'd9, 1'b1), 0);
      send(make_cmd(OP_ERASE, 3, 0, 0, 1'b0), 0);
      send(make_cmd(OP_SET, 1, 0, 32'h8000_0000, 1'b0), 0);

      for (phase = 0; phase < 4; phase++) begin
         pct = (phase == 1) ? 71 : (phase == 3) ? 37 : 0;
         if (phase == 2) fill_to_capacity(pct);
         while (items_sent < 24 + (phase + 1) * 407) random_seq(pct);
      end
      start <= 1'b0;

      while (board.replies_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.fails == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
